>>> rtl/phm_pkg.sv
// phm_pkg: shared types and constants of the path health monitor.
// Used by phm_rtt_alu and path_health_monitor; depends on nothing.
package phm_pkg;

  localparam int RTT_W  = 40;
  localparam int TIME_W = 48;
  localparam int CNT_W  = 32;
  localparam int CFG_W  = 24;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_EXEC = 5'b00010,
    S_JIT  = 5'b00100,
    S_SCAN = 5'b01000,
    S_OUT  = 5'b10000
  } state_e;

  localparam logic [2:0] CMD_SENT   = 3'd0;
  localparam logic [2:0] CMD_RECV   = 3'd1;
  localparam logic [2:0] CMD_LOST   = 3'd2;
  localparam logic [2:0] CMD_TICK   = 3'd3;
  localparam logic [2:0] CMD_SELECT = 3'd4;

  localparam logic [1:0] PS_UNKNOWN  = 2'd0;
  localparam logic [1:0] PS_ACTIVE   = 2'd1;
  localparam logic [1:0] PS_DEGRADED = 2'd2;
  localparam logic [1:0] PS_DOWN     = 2'd3;

  localparam logic [2:0] REG_HEARTBEAT = 3'd0;
  localparam logic [2:0] REG_RECONNECT = 3'd1;
  localparam logic [2:0] REG_PATHS     = 3'd2;
  localparam logic [2:0] REG_CURRENT   = 3'd3;
  localparam logic [2:0] REG_MULTIPATH = 3'd4;

endpackage

>>> rtl/phm_rtt_alu.sv
// phm_rtt_alu: shared 7/8 smoothing and absolute difference unit.
// Depends on phm_pkg.
module phm_rtt_alu import phm_pkg::*; (
  input  logic [RTT_W-1:0] acc_i,
  input  logic [RTT_W-1:0] sample_i,
  output logic [RTT_W-1:0] ewma_o,
  output logic [RTT_W-1:0] diff_o
);

  logic [RTT_W+3:0] sum;

  // (7*acc + sample) / 8
  assign sum    = {1'b0, acc_i, 3'b000} - {4'b0000, acc_i} + {4'b0000, sample_i};
  assign ewma_o = sum[RTT_W+2:3];
  assign diff_o = (acc_i > sample_i) ? (acc_i - sample_i) : (sample_i - acc_i);

endmodule

>>> rtl/path_health_monitor.sv
// path_health_monitor: per-path loss window, RTT statistics and path selection.
// Depends on phm_pkg and phm_rtt_alu.
//
//  channel  | ports                                  | handshake
//  request  | command_i path_i rtt_i now_i           | start_i while busy_o low
//  result   | ignored_o .. any_changed_o             | done_o, one cycle, no stall
//  config   | cfg_addr_i cfg_wdata_i                 | cfg_we_i, no wait
//
// A request runs S_EXEC and S_OUT before the next accept; a receive with an RTT
// sample on a path that already has an average adds S_JIT (extra jitter pass
// through the shared RTT unit). Tick and multipath select walk the paths one
// per cycle. Reset clears all path state at once. Results cannot be held off.
module path_health_monitor import phm_pkg::*; #(
  parameter int MAX_PATHS = 4,
  parameter int WIN_SLOTS = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  logic [2:0]        command_i,
  input  logic [3:0]        path_i,
  input  logic [RTT_W-1:0]  rtt_i,
  input  logic [TIME_W-1:0] now_i,
  input  logic              cfg_we_i,
  input  logic [2:0]        cfg_addr_i,
  input  logic [CFG_W-1:0]  cfg_wdata_i,
  output logic              done_o,
  output logic              ignored_o,
  output logic [1:0]        path_status_o,
  output logic [5:0]        window_losses_o,
  output logic [RTT_W-1:0]  smoothed_rtt_o,
  output logic [RTT_W-1:0]  rtt_jitter_o,
  output logic [RTT_W-1:0]  rtt_low_o,
  output logic [RTT_W-1:0]  rtt_high_o,
  output logic [CNT_W-1:0]  sent_total_o,
  output logic [CNT_W-1:0]  recv_total_o,
  output logic [CNT_W-1:0]  lost_total_o,
  output logic [1:0]        chosen_path_o,
  output logic              any_changed_o
);

  localparam int PW = (MAX_PATHS > 1) ? $clog2(MAX_PATHS) : 1;
  localparam int IW = $clog2(MAX_PATHS + 1);
  localparam int SW = $clog2(WIN_SLOTS);
  localparam int CW = $clog2(WIN_SLOTS + 1);

  // configuration
  logic [CFG_W-1:0] hb_q, rc_q;
  logic [2:0]       piu_q;
  logic [1:0]       cur_q;
  logic             mp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hb_q  <= CFG_W'(1000);
      rc_q  <= CFG_W'(5000);
      piu_q <= 3'd1;
      cur_q <= 2'd0;
      mp_q  <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        REG_HEARTBEAT: hb_q  <= cfg_wdata_i;
        REG_RECONNECT: rc_q  <= cfg_wdata_i;
        REG_PATHS:     piu_q <= cfg_wdata_i[2:0];
        REG_CURRENT:   cur_q <= cfg_wdata_i[1:0];
        REG_MULTIPATH: mp_q  <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // per-path state
  logic [1:0]             st_q   [MAX_PATHS];
  logic [WIN_SLOTS-1:0]   bits_q [MAX_PATHS];
  logic [SW-1:0]          slot_q [MAX_PATHS];
  logic [CW-1:0]          cnt_q  [MAX_PATHS];
  logic [RTT_W-1:0]       avg_q  [MAX_PATHS];
  logic [RTT_W-1:0]       jit_q  [MAX_PATHS];
  logic [RTT_W-1:0]       min_q  [MAX_PATHS];
  logic [RTT_W-1:0]       max_q  [MAX_PATHS];
  logic [TIME_W-1:0]      seen_q [MAX_PATHS];
  logic [CNT_W-1:0]       sent_q [MAX_PATHS];
  logic [CNT_W-1:0]       recv_q [MAX_PATHS];
  logic [CNT_W-1:0]       lost_q [MAX_PATHS];

  // sequencer and latched request
  state_e            state_q, state_d;
  logic [2:0]        cmd_q;
  logic [3:0]        p_q;
  logic [RTT_W-1:0]  rtt_q;
  logic [TIME_W-1:0] now_q;
  logic              ign_q;
  logic [IW-1:0]     idx_q;
  logic [PW-1:0]     best_q;
  logic [CW-1:0]     bl_q;
  logic [1:0]        chosen_q;
  logic              chg_q;
  logic [RTT_W-1:0]  dev_q;
  logic              done_q;

  logic              p_valid;
  logic [PW-1:0]     pi;
  logic [PW-1:0]     cur_sel;
  logic [4:0]        n_used;
  logic [PW-1:0]     rd_idx;

  assign p_valid = {1'b0, p_q} < 5'(MAX_PATHS);
  assign pi      = p_q[PW-1:0];
  assign cur_sel = ({3'b000, cur_q} < 5'(MAX_PATHS)) ? PW'(cur_q) : '0;
  assign n_used  = ({2'b00, piu_q} > 5'(MAX_PATHS)) ? 5'(MAX_PATHS) : {2'b00, piu_q};

  always_comb begin
    case (state_q)
      S_SCAN:  rd_idx = idx_q[PW-1:0];
      S_EXEC:  rd_idx = (cmd_q == CMD_SELECT) ? cur_sel : pi;
      default: rd_idx = pi;
    endcase
  end

  logic [1:0]             r_st;
  logic [WIN_SLOTS-1:0]   r_bits;
  logic [SW-1:0]          r_slot;
  logic [CW-1:0]          r_cnt;
  logic [RTT_W-1:0]       r_avg, r_jit, r_min, r_max;
  logic [TIME_W-1:0]      r_seen;

  assign r_st   = st_q[rd_idx];
  assign r_bits = bits_q[rd_idx];
  assign r_slot = slot_q[rd_idx];
  assign r_cnt  = cnt_q[rd_idx];
  assign r_avg  = avg_q[rd_idx];
  assign r_jit  = jit_q[rd_idx];
  assign r_min  = min_q[rd_idx];
  assign r_max  = max_q[rd_idx];
  assign r_seen = seen_q[rd_idx];

  // shared RTT unit
  logic [RTT_W-1:0] alu_acc, alu_smp, alu_ewma, alu_diff;
  assign alu_acc = state_q[2] ? r_jit : r_avg;
  assign alu_smp = state_q[2] ? dev_q : rtt_q;

  phm_rtt_alu u_alu (
    .acc_i    (alu_acc),
    .sample_i (alu_smp),
    .ewma_o   (alu_ewma),
    .diff_o   (alu_diff)
  );

  // loss window slot write
  logic                   lose;
  logic                   old_bit;
  logic [WIN_SLOTS-1:0]   new_bits;
  logic [SW-1:0]          new_slot;
  logic [CW-1:0]          new_cnt;
  logic [CW+3:0]          cnt10;
  logic                   over_deg, over_down;

  assign lose    = (cmd_q == CMD_LOST);
  assign old_bit = r_bits[r_slot];
  always_comb begin
    new_bits         = r_bits;
    new_bits[r_slot] = lose;
  end
  assign new_slot  = (r_slot == SW'(WIN_SLOTS - 1)) ? '0 : r_slot + SW'(1);
  assign new_cnt   = (lose && !old_bit) ? r_cnt + CW'(1) :
                     (!lose && old_bit) ? r_cnt - CW'(1) : r_cnt;
  assign cnt10     = {1'b0, new_cnt, 3'b000} + {3'b000, new_cnt, 1'b0};
  assign over_deg  = cnt10 > (CW+4)'(3 * WIN_SLOTS);
  assign over_down = {new_cnt, 1'b0} > (CW+1)'(WIN_SLOTS);

  // tick step
  logic [TIME_W-1:0] quiet;
  logic [CFG_W+1:0]  hb3;
  logic [1:0]        tk_st1, tk_st2;
  assign quiet  = now_q - r_seen;
  assign hb3    = {1'b0, hb_q, 1'b0} + {2'b00, hb_q};
  assign tk_st1 = (r_st == PS_ACTIVE && quiet > TIME_W'(hb3)) ? PS_DEGRADED : r_st;
  assign tk_st2 = (tk_st1 == PS_DEGRADED && quiet > TIME_W'(rc_q)) ? PS_DOWN : tk_st1;

  logic scan_end;
  assign scan_end = (idx_q == IW'(n_used));

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (start_i) state_d = S_EXEC;
      S_EXEC: begin
        if (cmd_q > CMD_SELECT || (cmd_q <= CMD_LOST && !p_valid)) begin
          state_d = S_OUT;
        end else begin
          case (cmd_q)
            CMD_RECV:   state_d = (rtt_q != '0 && r_avg != '0) ? S_JIT : S_OUT;
            CMD_TICK:   state_d = S_SCAN;
            CMD_SELECT: state_d = (n_used != 5'd0 && mp_q) ? S_SCAN : S_OUT;
            default:    state_d = S_OUT;
          endcase
        end
      end
      S_JIT:  state_d = S_OUT;
      S_SCAN: if (scan_end) state_d = S_OUT;
      S_OUT:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  assign busy_o = (state_q != S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
      ign_q   <= 1'b0;
      idx_q   <= '0;
      chg_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == S_OUT);
      case (state_q)
        S_IDLE: begin
          ign_q <= 1'b0;
          chg_q <= 1'b0;
          idx_q <= '0;
        end
        S_EXEC: ign_q <= cmd_q > CMD_SELECT || (cmd_q <= CMD_LOST && !p_valid);
        S_SCAN: begin
          if (!scan_end) begin
            idx_q <= idx_q + IW'(1);
            if (cmd_q == CMD_TICK && tk_st2 != r_st) chg_q <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // request capture, select search and datapath registers
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && start_i) begin
      cmd_q <= command_i;
      p_q   <= path_i;
      rtt_q <= rtt_i;
      now_q <= now_i;
    end
    if (state_q == S_EXEC) begin
      dev_q    <= alu_diff;
      best_q   <= cur_sel;
      bl_q     <= r_cnt;
      chosen_q <= (n_used == 5'd0) ? 2'd0 : cur_q;
    end
    if (state_q == S_SCAN && !scan_end && cmd_q == CMD_SELECT &&
        r_st == PS_ACTIVE && r_cnt < bl_q) begin
      best_q <= idx_q[PW-1:0];
      bl_q   <= r_cnt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < MAX_PATHS; k++) begin
        st_q[k]   <= PS_UNKNOWN;
        bits_q[k] <= '0;
        slot_q[k] <= '0;
        cnt_q[k]  <= '0;
        avg_q[k]  <= '0;
        jit_q[k]  <= '0;
        min_q[k]  <= '0;
        max_q[k]  <= '0;
        seen_q[k] <= '0;
        sent_q[k] <= '0;
        recv_q[k] <= '0;
        lost_q[k] <= '0;
      end
    end else begin
      case (state_q)
        S_EXEC: begin
          if (p_valid) begin
            case (cmd_q)
              CMD_SENT: sent_q[pi] <= sent_q[pi] + CNT_W'(1);
              CMD_RECV: begin
                recv_q[pi] <= recv_q[pi] + CNT_W'(1);
                bits_q[pi] <= new_bits;
                slot_q[pi] <= new_slot;
                cnt_q[pi]  <= new_cnt;
                if (rtt_q != '0) begin
                  if (r_min == '0 || rtt_q < r_min) min_q[pi] <= rtt_q;
                  if (rtt_q > r_max) max_q[pi] <= rtt_q;
                  avg_q[pi] <= (r_avg != '0) ? alu_ewma : rtt_q;
                end
                seen_q[pi] <= now_q;
                st_q[pi]   <= PS_ACTIVE;
              end
              CMD_LOST: begin
                lost_q[pi] <= lost_q[pi] + CNT_W'(1);
                bits_q[pi] <= new_bits;
                slot_q[pi] <= new_slot;
                cnt_q[pi]  <= new_cnt;
                if (over_down) st_q[pi] <= PS_DOWN;
                else if (over_deg) st_q[pi] <= PS_DEGRADED;
              end
              default: ;
            endcase
          end
        end
        S_JIT: jit_q[pi] <= (r_jit == '0) ? dev_q : alu_ewma;
        S_SCAN: begin
          if (!scan_end && cmd_q == CMD_TICK) st_q[idx_q[PW-1:0]] <= tk_st2;
        end
        default: ;
      endcase
    end
  end

  // result registers
  logic [3:0] best_ext;
  logic       show;
  assign best_ext = 4'(best_q);
  assign show     = !ign_q && p_valid;

  always_ff @(posedge clk_i) begin
    if (state_q == S_OUT) begin
      ignored_o       <= ign_q;
      path_status_o   <= show ? r_st : 2'd0;
      window_losses_o <= show ? 6'(r_cnt) : 6'd0;
      smoothed_rtt_o  <= show ? r_avg : '0;
      rtt_jitter_o    <= show ? r_jit : '0;
      rtt_low_o       <= show ? r_min : '0;
      rtt_high_o      <= show ? r_max : '0;
      sent_total_o    <= show ? sent_q[pi] : '0;
      recv_total_o    <= show ? recv_q[pi] : '0;
      lost_total_o    <= show ? lost_q[pi] : '0;
      chosen_path_o   <= (!ign_q && cmd_q == CMD_SELECT) ?
                         ((mp_q && n_used != 5'd0) ? best_ext[1:0] : chosen_q) : 2'd0;
      any_changed_o   <= !ign_q && cmd_q == CMD_TICK && chg_q;
    end
  end

  assign done_o = done_q;

endmodule
